[hw/rtl/stld_pkg.sv]
// Shared types and constants for the sync-word type-length deframer.
`default_nettype none

package stld_pkg;

	localparam int HEADER_BYTES = 8;
	localparam int FILL_W       = $clog2(HEADER_BYTES);

	localparam logic [7:0]  SYNC_A       = 8'h55;
	localparam logic [7:0]  SYNC_B       = 8'hCC;
	localparam logic [15:0] VIDEO_TYPE_A = 16'h574A;
	localparam logic [15:0] VIDEO_TYPE_D = 16'h574D;

	localparam logic [1:0] ROUTE_OTHER   = 2'd0;
	localparam logic [1:0] ROUTE_CONTROL = 2'd1;
	localparam logic [1:0] ROUTE_VIDEO   = 2'd2;

	localparam int          CFG_ADDR_W       = 1;
	localparam int          CFG_DATA_W       = 32;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_CONTROL_TYPE = 1'b1;

	localparam logic [31:0] MAX_PAYLOAD_RESET  = 32'd1048576;
	localparam logic [15:0] CONTROL_TYPE_RESET = 16'd0;

	typedef logic [7:0] byte_t;
	typedef byte_t [HEADER_BYTES-1:0] window_t;

	typedef struct packed {
		logic              commit;
		logic [FILL_W-1:0] fill;
		window_t           window;
		logic [15:0]       frame_type;
		logic [1:0]        route;
		logic [31:0]       length;
	} hdr_check_t;

endpackage

`default_nettype wire

[hw/rtl/stld_hdr_check.sv]
// Header window insert and check: sync hunt, length limit, type routing.
`default_nettype none

module stld_hdr_check (
	input  stld_pkg::window_t               window,
	input  logic [stld_pkg::FILL_W-1:0]     fill,
	input  stld_pkg::byte_t                 next_byte,
	input  logic [31:0]                     max_payload,
	input  logic [15:0]                     control_type,
	output stld_pkg::hdr_check_t            result
);
	import stld_pkg::*;

	always_comb begin
		window_t           w;
		window_t           shifted;
		logic              full;
		logic              sync_ok;
		logic              found;
		logic [FILL_W-1:0] at;
		logic [FILL_W-1:0] sh;
		logic [FILL_W:0]   idx;
		logic [FILL_W:0]   remain;

		w = window;
		w[fill] = next_byte;
		full = (fill == FILL_W'(HEADER_BYTES - 1));
		sync_ok = (w[0] == SYNC_A) && (w[1] == SYNC_B);

		// first 55 CC pair past the front
		found = 1'b0;
		at = '0;
		for (int i = 1; i < HEADER_BYTES - 1; i++) begin
			if (!found && w[i] == SYNC_A && w[i+1] == SYNC_B) begin
				found = 1'b1;
				at = FILL_W'(i);
			end
		end

		sh = sync_ok ? FILL_W'(1) : at;
		for (int j = 0; j < HEADER_BYTES; j++) begin
			idx = (FILL_W+1)'(j) + {1'b0, sh};
			shifted[j] = (idx < (FILL_W+1)'(HEADER_BYTES)) ? w[idx[FILL_W-1:0]] : '0;
		end
		remain = (FILL_W+1)'(HEADER_BYTES) - {1'b0, sh};

		result.length = {w[7], w[6], w[5], w[4]};
		result.frame_type = {w[3], w[2]};
		if (result.frame_type == control_type) begin
			result.route = ROUTE_CONTROL;
		end else if (result.frame_type == VIDEO_TYPE_A || result.frame_type == VIDEO_TYPE_D) begin
			result.route = ROUTE_VIDEO;
		end else begin
			result.route = ROUTE_OTHER;
		end

		result.commit = 1'b0;
		result.fill = fill + FILL_W'(1);
		result.window = w;
		if (full) begin
			if (sync_ok) begin
				if (result.length > max_payload) begin
					result.window = shifted;
					result.fill = remain[FILL_W-1:0];
				end else begin
					result.commit = 1'b1;
					result.fill = '0;
				end
			end else if (found) begin
				result.window = shifted;
				result.fill = remain[FILL_W-1:0];
			end else if (w[HEADER_BYTES-1] == SYNC_A) begin
				// keep a trailing sync byte as the new front
				result.window[0] = SYNC_A;
				result.fill = FILL_W'(1);
			end else begin
				result.fill = '0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sof_type_length_deframer_unit.sv]
// Top level of the sync-word type-length deframer.
//
// Usage:
//   s_* carries one raw link byte per word (s_tdata). Frames on the link are
//   55 CC, a 16-bit little-endian type, a 32-bit little-endian length and
//   that many payload bytes. m_* carries one word per payload byte, tagged
//   with type, route, first/last marks and the running frame count; a
//   zero-length frame gives a single word flagged empty with payload 0.
//   Header bytes and rejected garbage produce no output word.
//   cfg_we/cfg_addr/cfg_wdata write max_payload (index 0) and control_type
//   (index 1); write them only while the block is idle.
// Timing:
//   One byte per cycle sustained while m_tready stays high. A byte is held in
//   the input register, passes the header check logic and lands in the result
//   register, which drives m_tvalid.
// Reset:
//   arst_n clears window, fill, frame state and both valids; loads register resets.
// Backpressure:
//   With m_tready low and a word pending, hold the input byte; s_tready drops
//   once the input stage is full. Nothing is lost or repeated.
`default_nettype none

module sof_type_length_deframer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave stream: tdata[7:0] data_byte
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,
	// master stream: tdata[7:0] payload_byte, [23:8] frame_type, [55:24] frame_count
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [55:0]                       m_tdata,
	// tuser[1:0] route, [2] first_flag, [3] empty_frame
	output logic [3:0]                        m_tuser,
	output logic                              m_tlast,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [stld_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [stld_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import stld_pkg::*;

	// input stage
	logic              valid_s1;
	byte_t             byte_s1;

	// config registers
	logic [31:0]       max_payload_q;
	logic [15:0]       control_type_q;

	// deframer state
	window_t           window_q;
	logic [FILL_W-1:0] fill_q;
	logic              in_payload_q;
	logic [31:0]       remain_q;
	logic [15:0]       type_q;
	logic [1:0]        route_q;
	logic              first_pend_q;
	logic [31:0]       frame_cnt_q;   // frames done plus one

	// result register
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [15:0]       out_type_q;
	logic [1:0]        out_route_q;
	logic              out_first_q;
	logic              out_last_q;
	logic              out_empty_q;
	logic [31:0]       out_count_q;

	hdr_check_t        hc;
	logic              advance;
	logic              step;
	logic              pay_last;
	logic              emit_empty;

	// advance the input stage whenever the result slot is free or being drained
	assign advance    = !out_valid_q || m_tready;
	assign s_tready   = !valid_s1 || advance;
	assign step       = valid_s1 && advance;
	assign pay_last   = (remain_q == 32'd1);
	assign emit_empty = !in_payload_q && hc.commit && (hc.length == 32'd0);

	stld_hdr_check u_hdr_check (
		.window       (window_q),
		.fill         (fill_q),
		.next_byte    (byte_s1),
		.max_payload  (max_payload_q),
		.control_type (control_type_q),
		.result       (hc)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q  <= MAX_PAYLOAD_RESET;
			control_type_q <= CONTROL_TYPE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MAX_PAYLOAD:  max_payload_q  <= cfg_wdata[31:0];
				REG_CONTROL_TYPE: control_type_q <= cfg_wdata[15:0];
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			fill_q       <= '0;
			in_payload_q <= 1'b0;
			remain_q     <= '0;
			type_q       <= '0;
			route_q      <= ROUTE_OTHER;
			first_pend_q <= 1'b0;
			frame_cnt_q  <= 32'd1;
		end else if (step) begin
			if (in_payload_q) begin
				first_pend_q <= 1'b0;
				remain_q     <= remain_q - 32'd1;
				if (pay_last) begin
					in_payload_q <= 1'b0;
					frame_cnt_q  <= frame_cnt_q + 32'd1;
				end
			end else begin
				window_q <= hc.window;
				fill_q   <= hc.fill;
				if (hc.commit) begin
					type_q  <= hc.frame_type;
					route_q <= hc.route;
					if (hc.length == 32'd0) begin
						frame_cnt_q <= frame_cnt_q + 32'd1;
					end else begin
						remain_q     <= hc.length;
						in_payload_q <= 1'b1;
						first_pend_q <= 1'b1;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && (in_payload_q || emit_empty);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_count_q <= frame_cnt_q;
			if (in_payload_q) begin
				out_byte_q  <= byte_s1;
				out_type_q  <= type_q;
				out_route_q <= route_q;
				out_first_q <= first_pend_q;
				out_last_q  <= pay_last;
				out_empty_q <= 1'b0;
			end else begin
				out_byte_q  <= '0;
				out_type_q  <= hc.frame_type;
				out_route_q <= hc.route;
				out_first_q <= 1'b1;
				out_last_q  <= 1'b1;
				out_empty_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_type_q, out_byte_q};
	assign m_tuser  = {out_empty_q, out_first_q, out_route_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_fill_idle_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (fill_q == '0))
		else $error("header window not empty during payload");

	a_remain_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (remain_q != 32'd0))
		else $error("payload active with no bytes remaining");

	a_empty_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3]) |-> (m_tuser[2] && m_tlast && m_tdata[7:0] == 8'd0))
		else $error("empty frame word without first/last marks");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && valid_s1) |-> !s_tready)
		else $error("input accepted while both stages are held");

	a_count_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(step && in_payload_q && !pay_last) |=> $stable(frame_cnt_q))
		else $error("frame count moved inside a frame");
`endif

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for the sync-word type-length deframer: scoreboard, stream drivers and checks.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stld_pkg::*;

	// Cycles with no word moving on either stream before the run is declared hung.
	// The worst honest pause is a long sender gap plus a long receiver stall, well under this.
	localparam int HANG_LIMIT = 2000;
	// Cycles to let the two-stage pipeline drain after the last expected word.
	localparam int DRAIN_CYCLES = 4;

	// One output word as the deframer should produce it.
	typedef struct {
		logic [7:0]  payload;
		logic [15:0] ftype;
		logic [1:0]  route;
		logic        first;
		logic        last;
		logic        empty;
		logic [31:0] count;
	} deframe_word_t;

	// Scoreboard: mirrors the deframer state, predicts words, checks the output stream.
	class deframe_scoreboard;
		logic [31:0]   max_len;
		logic [15:0]   ctrl_type;
		logic [7:0]    win [HEADER_BYTES];
		int            fill;
		bit            in_frame;
		bit            first_due;
		logic [31:0]   remaining;
		logic [15:0]   cur_type;
		logic [1:0]    cur_route;
		logic [31:0]   done_count;
		deframe_word_t expected [$];
		int            errors;
		int            words_checked;
		int            frames_seen;
		int            empties_seen;
		int            control_seen;
		int            video_seen;

		function new();
			max_len    = MAX_PAYLOAD_RESET;
			ctrl_type  = CONTROL_TYPE_RESET;
			foreach (win[k])
				win[k] = '0;
			fill       = 0;
			in_frame   = 0;
			first_due  = 0;
			remaining  = '0;
			cur_type   = '0;
			cur_route  = ROUTE_OTHER;
			done_count = '0;
		endfunction

		function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
			case (idx)
				REG_MAX_PAYLOAD: begin
					max_len = val;
				end
				REG_CONTROL_TYPE: begin
					ctrl_type = val[15:0];
				end
				default: begin
				end
			endcase
		endfunction

		function bit idle();
			return (fill == 0) && !in_frame;
		endfunction

		function void queue_word(logic [7:0] b, bit first, bit last, bit empty);
			deframe_word_t w;
			w.payload = b;
			w.ftype   = cur_type;
			w.route   = cur_route;
			w.first   = first;
			w.last    = last;
			w.empty   = empty;
			w.count   = done_count + 32'd1;
			expected.insert(expected.size(), w);
		endfunction

		function void drop_front(int n);
			if (n >= fill) begin
				fill = 0;
			end else begin
				for (int k = 0; k < fill - n; k++)
					win[k] = win[k + n];
				fill = fill - n;
			end
		endfunction

		// Advance the mirrored state by one accepted link byte.
		function void note_byte(logic [7:0] b);
			logic [31:0] len;
			int          at;
			bit          settled;
			if (in_frame) begin
				remaining = remaining - 32'd1;
				queue_word(b, first_due, remaining == 0, 1'b0);
				first_due = 0;
				if (remaining == 0) begin
					in_frame   = 0;
					done_count = done_count + 32'd1;
				end
				return;
			end
			if (fill >= HEADER_BYTES)
				fill = 0;
			win[fill] = b;
			fill++;
			settled = 0;
			while (!settled && fill >= HEADER_BYTES) begin
				if (!(win[0] == SYNC_A && win[1] == SYNC_B)) begin
					at = 0;
					for (int k = 1; k + 1 < fill; k++)
						if (at == 0 && win[k] == SYNC_A && win[k + 1] == SYNC_B)
							at = k;
					if (at != 0) begin
						drop_front(at);
					end else begin
						if (win[fill - 1] == SYNC_A) begin
							win[0] = SYNC_A;
							fill   = 1;
						end else begin
							fill = 0;
						end
						settled = 1;
					end
				end else begin
					len = {win[7], win[6], win[5], win[4]};
					if (len > max_len) begin
						drop_front(1);
					end else begin
						cur_type = {win[3], win[2]};
						if (cur_type == ctrl_type)
							cur_route = ROUTE_CONTROL;
						else if (cur_type == VIDEO_TYPE_A || cur_type == VIDEO_TYPE_D)
							cur_route = ROUTE_VIDEO;
						else
							cur_route = ROUTE_OTHER;
						frames_seen++;
						if (cur_route == ROUTE_CONTROL)
							control_seen++;
						if (cur_route == ROUTE_VIDEO)
							video_seen++;
						fill = 0;
						if (len == 0) begin
							empties_seen++;
							queue_word(8'h00, 1'b1, 1'b1, 1'b1);
							done_count = done_count + 32'd1;
						end else begin
							remaining = len;
							in_frame  = 1;
							first_due = 1;
						end
						settled = 1;
					end
				end
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_word(logic [55:0] d, logic [3:0] u, logic l);
			deframe_word_t w;
			if (expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual data %h user %h last %b",
					$time, d, u, l);
				return;
			end
			w = expected.pop_front();
			words_checked++;
			compare_field("payload_byte", 32'(w.payload), 32'(d[7:0]));
			compare_field("frame_type", 32'(w.ftype), 32'(d[23:8]));
			compare_field("frame_count", w.count, d[55:24]);
			compare_field("route", 32'(w.route), 32'(u[1:0]));
			compare_field("first_flag", 32'(w.first), 32'(u[2]));
			compare_field("empty_frame", 32'(w.empty), 32'(u[3]));
			compare_field("last_flag", 32'(w.last), 32'(l));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [55:0]           m_tdata;
	logic [3:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	deframe_scoreboard sb;
	int  bytes_sent;
	int  hang_count;
	// calm: no sender gaps and no receiver stalls while set
	bit  calm;

	sof_type_length_deframer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap before the next link byte: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Link byte biased toward the sync bytes so false syncs show up often.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return SYNC_A;
		if (r < 20)
			return SYNC_B;
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one byte on the slave stream and hold it until taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = gap_len();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// Send a header with the given type and length field, then payload_n payload bytes.
	task automatic send_frame(input logic [15:0] ftype, input logic [31:0] len, input int payload_n);
		send_byte(SYNC_A);
		send_byte(SYNC_B);
		send_byte(ftype[7:0]);
		send_byte(ftype[15:8]);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		send_byte(len[23:16]);
		send_byte(len[31:24]);
		repeat (payload_n)
			send_byte(pick_byte());
	endtask

	// One frame with random type; usually well-formed, sometimes an oversize length.
	task automatic send_random_frame(input bit allow_reject);
		logic [15:0] ftype;
		logic [31:0] len;
		int          cap;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 25)
			ftype = VIDEO_TYPE_A;
		else if (r < 40)
			ftype = VIDEO_TYPE_D;
		else if (r < 60)
			ftype = sb.ctrl_type;
		else
			ftype = 16'($urandom_range(0, 65535));
		if (allow_reject && sb.max_len != 32'hFFFF_FFFF && $urandom_range(0, 99) < 15) begin
			len = $urandom;
			if (len <= sb.max_len)
				len = sb.max_len + 32'd1;
			send_frame(ftype, len, $urandom_range(0, 3));
		end else begin
			cap = (sb.max_len < 12) ? int'(sb.max_len) : 12;
			len = $urandom_range(0, cap);
			send_frame(ftype, len, int'(len));
		end
	endtask

	// Drop valid, wait for every expected word, then let the pipeline settle.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	// Push zeros until the deframer sits between frames with an empty window.
	task automatic flush_link();
		while (!sb.idle())
			send_byte(8'h00);
	endtask

	// Mixed traffic: mostly frames, some noise runs and some cut-off headers.
	task automatic random_traffic(input int budget);
		int start;
		int r;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_random_frame(1'b1);
			end else if (r < 87) begin
				repeat ($urandom_range(1, 6))
					send_byte(pick_byte());
			end else begin
				send_byte(SYNC_A);
				send_byte(SYNC_B);
				repeat ($urandom_range(0, 5))
					send_byte(pick_byte());
			end
		end
	endtask

	// Receiver: random runs of ready and stalls, held high in calm stretches.
	initial begin : receiver
		int  n;
		int  r;
		bit  level;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					level = 1'b1;
					n     = $urandom_range(1, 6);
				end else if (r < 92) begin
					level = 1'b0;
					n     = $urandom_range(1, 3);
				end else begin
					level = 1'b0;
					n     = $urandom_range(10, 40);
				end
				repeat (n) begin
					@(negedge clk);
					m_tready <= level;
				end
			end
		end
	end

	// Check every word taken on the master stream.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tuser, m_tlast);
	end

	// Watchdog: give up when neither stream moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				hang_count = 0;
			else
				hang_count++;
			if (hang_count >= HANG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0]  seq [$];
		logic [31:0] max_pick;
		logic [15:0] ctrl_pick;
		int          r;
		sb         = new();
		bytes_sent = 0;
		hang_count = 0;
		calm       = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 8'h00;
		cfg_we     = 1'b0;
		cfg_addr   = REG_MAX_PAYLOAD;
		cfg_wdata  = '0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, at reset register values.
		// Zero-length frame of type 0: single empty word on the control route.
		send_frame(16'h0000, 32'd0, 0);
		// Bad sync with 55 CC inside the window: realign, then a video-D frame of
		// two bytes whose payload looks like a sync word and must pass untouched.
		seq = '{8'h00, 8'hAA, 8'h55, 8'hCC, 8'h4D, 8'h57, 8'h02, 8'h00,
			8'h00, 8'h00, 8'h55, 8'hCC};
		foreach (seq[k])
			send_byte(seq[k]);
		// Garbage window ending in 0x55: keep it as the start of the next header,
		// here an empty frame of type FFFF.
		seq = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h66, 8'h77, 8'h88, 8'h55,
			8'hCC, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
		foreach (seq[k])
			send_byte(seq[k]);
		// Oversize length: drop one byte, rescan, then discard the leftovers.
		seq = '{8'h55, 8'hCC, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		foreach (seq[k])
			send_byte(seq[k]);
		flush_link();

		// Widest length limit, control type equal to a video type: clean frames only,
		// since a false sync here could commit an endless payload.
		wait_idle();
		write_reg(REG_MAX_PAYLOAD, 32'hFFFF_FFFF);
		write_reg(REG_CONTROL_TYPE, {16'h0000, VIDEO_TYPE_A});
		repeat (20)
			send_random_frame(1'b0);

		// Zero length limit: only empty frames commit, everything else is garbage.
		wait_idle();
		write_reg(REG_MAX_PAYLOAD, 32'd0);
		write_reg(REG_CONTROL_TYPE, 32'h0000_FFFF);
		random_traffic(100);

		// Random settings with small limits so false syncs stay short.
		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			r = $urandom_range(0, 99);
			if (r < 15)
				max_pick = 32'd0;
			else if (r < 30)
				max_pick = $urandom_range(1, 3);
			else
				max_pick = $urandom_range(4, 40);
			r = $urandom_range(0, 99);
			if (r < 20)
				ctrl_pick = VIDEO_TYPE_D;
			else if (r < 30)
				ctrl_pick = 16'hFFFF;
			else if (r < 40)
				ctrl_pick = 16'h0000;
			else
				ctrl_pick = 16'($urandom_range(0, 65535));
			write_reg(REG_MAX_PAYLOAD, max_pick);
			write_reg(REG_CONTROL_TYPE, {16'h0000, ctrl_pick});
			calm = (phase == 2);
			random_traffic(110);
		end
		calm = 1'b0;

		// Drain: everything expected must arrive, then nothing more may follow.
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);

		$display("Sent %0d link bytes; checked %0d output words over %0d frames.",
			bytes_sent, sb.words_checked, sb.frames_seen);
		$display("Frames: %0d empty, %0d control route, %0d video route; %0d mismatches.",
			sb.empties_seen, sb.control_seen, sb.video_seen, sb.errors);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/stld_pkg.sv
hw/rtl/stld_hdr_check.sv
hw/rtl/sof_type_length_deframer_unit.sv
test/tb.sv
